// ----- rtl/hcm37_pkg.sv -----
// Package for the mod-37 Hill cipher encrypt core.
// Holds widths, register indexes, alphabet constants and the symbol mapping functions.
// No dependencies.
package hcm37_pkg;

    localparam int MAX_ORDER  = 4;
    localparam int ROW_W      = $clog2(MAX_ORDER);
    localparam int SYM_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int KEY_W      = MAX_ORDER * SYM_W;
    localparam int PROD_W     = 2 * SYM_W;
    localparam int SUM_W      = PROD_W + $clog2(MAX_ORDER);
    localparam int CFG_IDX_W  = 3;
    localparam int BSIZE_W    = 3;

    localparam int ALPHA_SIZE = 37;
    localparam int NUM_LETTER = 26;
    localparam int NUM_DIGIT  = 10;

    // floor(s / 37) == (s * RECIP_37) >> RECIP_SHIFT for every s below 2^SUM_W
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_37    = ((1 << RECIP_SHIFT) + ALPHA_SIZE - 1) / ALPHA_SIZE;
    localparam int QUOT_W      = SUM_W - 5;
    localparam int MUL_W       = SUM_W + RECIP_SHIFT;

    localparam logic [SYM_W-1:0]  PAD_SYMBOL = SYM_W'(ALPHA_SIZE - 1);
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_3  = 3'd4;

    typedef logic [SYM_W-1:0] t_sym;

    // ASCII to symbol; anything outside the alphabet maps to symbol 0
    function automatic t_sym to_symbol(input logic [CHAR_W-1:0] ch);
        t_sym s;
        if (ch >= CHAR_A && ch <= CHAR_Z) begin
            s = SYM_W'(ch - CHAR_A);
        end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
            s = SYM_W'(ch - CHAR_0) + SYM_W'(NUM_LETTER);
        end else if (ch == CHAR_SPACE) begin
            s = PAD_SYMBOL;
        end else begin
            s = '0;
        end
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] to_char(input t_sym s);
        logic [CHAR_W-1:0] c;
        if (s < SYM_W'(NUM_LETTER)) begin
            c = CHAR_A + CHAR_W'(s);
        end else if (s < SYM_W'(NUM_LETTER + NUM_DIGIT)) begin
            c = CHAR_0 + CHAR_W'(s - SYM_W'(NUM_LETTER));
        end else begin
            c = CHAR_SPACE;
        end
        return c;
    endfunction

endpackage

// ----- rtl/hill_cipher_mod37_encrypt_core.sv -----
// Hill cipher encrypt core over a 37-symbol alphabet (A-Z, 0-9, space).
// Throughput unless i_out_ready stalls: one plain word per cycle; a block of n words
// drains one row per cycle through the single row dot-product unit, overlapped with
// filling of the next block. Each block passes block hold, sum and output registers.
// Reset (i_rst_n low, synchronous): block size 1, key rows zero, buffers empty.
// Depends on hcm37_pkg.
module hill_cipher_mod37_encrypt_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hcm37_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hcm37_pkg::KEY_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [hcm37_pkg::CHAR_W-1:0]      i_plain_char,
    input  logic                              i_end_of_message,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [hcm37_pkg::CHAR_W-1:0]      o_cipher_char,
    output logic                              o_last_of_block,
    output logic                              o_last_of_message
);

    localparam int M   = hcm37_pkg::MAX_ORDER;
    localparam int RW  = hcm37_pkg::ROW_W;
    localparam int SW  = hcm37_pkg::SYM_W;

    // configuration
    logic [hcm37_pkg::BSIZE_W-1:0] r_block_size;
    logic [hcm37_pkg::KEY_W-1:0]   r_key [M];

    // fill stage
    hcm37_pkg::t_sym r_sym [M];
    logic [RW-1:0]   r_fill;

    // block hold stage
    logic            r_blk_valid;
    hcm37_pkg::t_sym r_blk_sym [M];
    logic            r_blk_last;
    logic [RW-1:0]   r_row;

    // sum stage
    logic                          r_s_valid;
    logic [hcm37_pkg::SUM_W-1:0]   r_s_sum;
    logic                          r_s_lob;
    logic                          r_s_lom;

    // output register
    logic                          r_out_valid;
    logic [hcm37_pkg::CHAR_W-1:0]  r_out_char;
    logic                          r_out_lob;
    logic                          r_out_lom;

    logic [RW-1:0]   n_m1;
    logic [RW-1:0]   pos;
    hcm37_pkg::t_sym new_sym;
    logic            complete;
    logic            in_acc;
    logic            out_free;
    logic            s_free;
    logic            drain;
    logic            last_row;
    logic            blk_free;
    logic [hcm37_pkg::SUM_W-1:0]  n_sum;
    logic [hcm37_pkg::MUL_W-1:0]  mul;
    logic [hcm37_pkg::QUOT_W-1:0] quot;
    logic [hcm37_pkg::SUM_W-1:0]  rem;

    // effective order minus one: 0 counts as 1, above MAX_ORDER clamps
    always_comb begin
        if (r_block_size == '0) begin
            n_m1 = '0;
        end else if (r_block_size > hcm37_pkg::BSIZE_W'(M)) begin
            n_m1 = RW'(M - 1);
        end else begin
            n_m1 = RW'(r_block_size - 1'b1);
        end
    end

    assign pos      = (r_fill > n_m1) ? n_m1 : r_fill;
    assign new_sym  = hcm37_pkg::to_symbol(i_plain_char);
    assign complete = (pos == n_m1) || i_end_of_message;

    assign out_free = !r_out_valid || i_out_ready;
    assign s_free   = !r_s_valid || out_free;
    assign last_row = (r_row == n_m1);
    assign drain    = r_blk_valid && s_free;
    assign blk_free = !r_blk_valid || (s_free && last_row);

    assign o_in_ready  = !complete || blk_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= hcm37_pkg::BSIZE_W'(1);
            for (int k = 0; k < M; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hcm37_pkg::REG_BLOCK_SIZE: r_block_size <= i_cfg_data[hcm37_pkg::BSIZE_W-1:0];
                hcm37_pkg::REG_KEY_ROW_0:  r_key[0] <= i_cfg_data;
                hcm37_pkg::REG_KEY_ROW_1:  r_key[1] <= i_cfg_data;
                hcm37_pkg::REG_KEY_ROW_2:  r_key[2] <= i_cfg_data;
                hcm37_pkg::REG_KEY_ROW_3:  r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // fill buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (in_acc) begin
            r_fill <= complete ? '0 : RW'(pos + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sym[pos] <= new_sym;
        end
    end

    // block hold: padded copy; slots past the order are zero so they drop out of the sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_valid <= 1'b0;
            r_row       <= '0;
        end else if (in_acc && complete) begin
            r_blk_valid <= 1'b1;
            r_row       <= '0;
        end else if (drain) begin
            if (last_row) begin
                r_blk_valid <= 1'b0;
                r_row       <= '0;
            end else begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && complete) begin
            r_blk_last <= i_end_of_message;
            for (int j = 0; j < M; j++) begin
                if (RW'(j) > n_m1) begin
                    r_blk_sym[j] <= '0;
                end else if (RW'(j) < pos) begin
                    r_blk_sym[j] <= r_sym[j];
                end else if (RW'(j) == pos) begin
                    r_blk_sym[j] <= new_sym;
                end else begin
                    r_blk_sym[j] <= hcm37_pkg::PAD_SYMBOL;
                end
            end
        end
    end

    // row dot product
    always_comb begin
        n_sum = '0;
        for (int j = 0; j < M; j++) begin
            n_sum = n_sum + hcm37_pkg::SUM_W'(r_key[r_row][j*SW +: SW])
                          * hcm37_pkg::SUM_W'(r_blk_sym[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (s_free) begin
            r_s_valid <= r_blk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_s_sum <= n_sum;
            r_s_lob <= last_row;
            r_s_lom <= last_row && r_blk_last;
        end
    end

    // sum mod 37 by reciprocal multiply; quotient is exact over the sum range
    always_comb begin
        mul  = hcm37_pkg::MUL_W'(r_s_sum) * hcm37_pkg::MUL_W'(hcm37_pkg::RECIP_37);
        quot = mul[hcm37_pkg::RECIP_SHIFT +: hcm37_pkg::QUOT_W];
        rem  = r_s_sum - ((hcm37_pkg::SUM_W'(quot) << 5) + (hcm37_pkg::SUM_W'(quot) << 2)
                          + hcm37_pkg::SUM_W'(quot));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s_valid) begin
            r_out_char <= hcm37_pkg::to_char(rem[SW-1:0]);
            r_out_lob  <= r_s_lob;
            r_out_lom  <= r_s_lom;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cipher_char     = r_out_char;
    assign o_last_of_block   = r_out_lob;
    assign o_last_of_message = r_out_lom;

    a_lom_ends_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_lom |-> r_out_lob)
        else $error("last_of_message without last_of_block");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk_valid |-> r_row <= n_m1)
        else $error("row counter past block order");

    a_char_in_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_char >= hcm37_pkg::CHAR_A && r_out_char <= hcm37_pkg::CHAR_Z)
                         || (r_out_char >= hcm37_pkg::CHAR_0 && r_out_char <= hcm37_pkg::CHAR_9)
                         || r_out_char == hcm37_pkg::CHAR_SPACE))
        else $error("cipher word outside alphabet");

    a_fill_empty_after_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && complete |=> r_fill == '0 && r_blk_valid)
        else $error("block close did not reset fill");

endmodule
